// ===== hdl/median_filter_3x3_stream_core_macros.svh =====
// Assertion macros for the 3x3 median filter stream core.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef MEDIAN_FILTER_3X3_STREAM_CORE_MACROS_SVH
`define MEDIAN_FILTER_3X3_STREAM_CORE_MACROS_SVH

// Checked out of reset only.
`define MF3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MF3_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mf3_pkg.sv =====
// Shared types, constants and compare helpers for the 3x3 median filter.
// No dependencies.
`timescale 1ns / 1ps

package mf3_pkg;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int COUNT_LIMIT = 4096;
  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 480;
  localparam int MIN_SIZE   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef pix_t [2:0] col_t;

  typedef struct packed {
    pix_t p;
    pix_t mid;
    pos_t x;
    pos_t y;
    logic f_med;
    logic f_bord;
    logic f_echo;
  } side_t;

  // Last index (size - 1) after holding the size to MIN_SIZE .. limit.
  function automatic pos_t last_index(logic [SIZE_W-1:0] v, int limit);
    pos_t r;
    if (int'(v) < MIN_SIZE) begin
      r = POS_W'(MIN_SIZE - 1);
    end else if (int'(v) > limit) begin
      r = POS_W'(limit - 1);
    end else begin
      r = POS_W'(v - SIZE_W'(1));
    end
    return r;
  endfunction

  function automatic col_t sort3(col_t c);
    pix_t a;
    pix_t b;
    pix_t d;
    pix_t t;
    col_t r;
    a = c[0];
    b = c[1];
    d = c[2];
    if (a > b) begin
      t = a; a = b; b = t;
    end
    if (b > d) begin
      t = b; b = d; d = t;
    end
    if (a > b) begin
      t = a; a = b; b = t;
    end
    r[0] = a;
    r[1] = b;
    r[2] = d;
    return r;
  endfunction

  function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
    pix_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
    pix_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    col_t s;
    s = sort3({c, b, a});
    return s[1];
  endfunction

endpackage

// ===== hdl/mf3_ifs.sv =====
// Stream and configuration channel interfaces of the 3x3 median filter.
// Depends on mf3_pkg.
`timescale 1ns / 1ps

interface mf3_pix_if;
  logic               valid;
  logic               ready;
  logic [mf3_pkg::PIX_W-1:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface mf3_res_if;
  logic               valid;
  logic               ready;
  logic [mf3_pkg::PIX_W-1:0] pixel_out;
  logic [mf3_pkg::POS_W-1:0] out_col;
  logic [mf3_pkg::POS_W-1:0] out_row;
  logic               run_last;
  modport source (output valid, output pixel_out, output out_col, output out_row,
                  output run_last, input ready);
  modport sink (input valid, input pixel_out, input out_col, input out_row,
                input run_last, output ready);
endinterface

interface mf3_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mf3_pkg::CFG_IDX_W-1:0] index;
  logic [mf3_pkg::SIZE_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/median_filter_3x3_stream_core.sv =====
// 3x3 median filter stream core: takes one pixel per clock in raster order and
// gives each output pixel as its own result transfer. Throughput is one pixel per
// clock while each pixel causes at most one result and the result port is not stalled; a
// pixel with two or three results (the last column from row two on, and every pixel
// of the final row except the one in column 1) holds the input until the single
// result port has sent them all. Both line buffers share one RAM of MAX_WIDTH words
// with a registered read, read at the pixel's column when it arrives and written
// back on the next stage; there is no clearing pass after reset. Writing either size
// register restarts the frame at row 0, column 0.
// Depends on mf3_pkg, mf3_ifs, mf3_ram, mf3_median and mf3_serial.
`timescale 1ns / 1ps

module median_filter_3x3_stream_core #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  mf3_pix_if.sink    in_ch,
  mf3_res_if.source  out_ch,
  mf3_cfg_if.sink    cfg_ch
);

  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int WIDTH_LIM = (MAX_WIDTH < mf3_pkg::COUNT_LIMIT) ? MAX_WIDTH
                                                                : mf3_pkg::COUNT_LIMIT;

  mf3_pkg::pos_t          last_col_r;
  mf3_pkg::pos_t          last_row_r;
  mf3_pkg::pos_t          col_r;
  mf3_pkg::pos_t          row_r;
  logic                   advance;
  logic                   accept;
  logic                   cfg_wr;
  logic                   s1_v_r;
  mf3_pkg::side_t         s1_side_r;
  mf3_pkg::side_t         s1_tag;
  logic [mf3_pkg::LINE_W-1:0] rd_word;
  mf3_pkg::pix_t          rd_up;
  mf3_pkg::pix_t          rd_mid;
  mf3_pkg::col_t [1:0]    win_r;
  mf3_pkg::col_t [2:0]    win_nxt;
  logic                   med_v;
  mf3_pkg::side_t         med_tag;
  mf3_pkg::pix_t          med_pix;
  logic                   ser_take;
  logic                   row_ge2;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;
  assign advance      = !med_v || ser_take;
  assign in_ch.ready  = advance;
  assign accept       = in_ch.valid && advance;
  assign row_ge2      = |row_r[mf3_pkg::POS_W-1:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= mf3_pkg::last_index(mf3_pkg::SIZE_W'(mf3_pkg::RST_WIDTH), WIDTH_LIM);
      last_row_r <= mf3_pkg::last_index(mf3_pkg::SIZE_W'(mf3_pkg::RST_HEIGHT),
                                        mf3_pkg::COUNT_LIMIT);
      col_r      <= '0;
      row_r      <= '0;
      s1_v_r     <= 1'b0;
      win_r      <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_ch.index)
          mf3_pkg::REG_IMAGE_WIDTH: begin
            last_col_r <= mf3_pkg::last_index(cfg_ch.data, WIDTH_LIM);
            col_r      <= '0;
            row_r      <= '0;
          end
          mf3_pkg::REG_IMAGE_HEIGHT: begin
            last_row_r <= mf3_pkg::last_index(cfg_ch.data, mf3_pkg::COUNT_LIMIT);
            col_r      <= '0;
            row_r      <= '0;
          end
          default: begin
          end
        endcase
      end else if (accept) begin
        if (col_r == last_col_r) begin
          col_r <= '0;
          row_r <= (row_r == last_row_r) ? '0 : row_r + mf3_pkg::POS_W'(1);
        end else begin
          col_r <= col_r + mf3_pkg::POS_W'(1);
        end
      end
      if (advance) begin
        s1_v_r <= accept;
      end
      if (s1_v_r && advance) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_nxt[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_side_r.p      <= in_ch.pixel_in;
      s1_side_r.mid    <= '0;
      s1_side_r.x      <= col_r;
      s1_side_r.y      <= row_r;
      s1_side_r.f_med  <= row_ge2 && (|col_r[mf3_pkg::POS_W-1:1]);
      s1_side_r.f_bord <= row_ge2 && ((col_r == '0) || (col_r == last_col_r));
      s1_side_r.f_echo <= (row_r == '0) || (row_ge2 && (row_r == last_row_r));
    end
  end

  // word layout: upper row in the high byte, middle row in the low byte
  assign rd_up  = rd_word[mf3_pkg::LINE_W-1:mf3_pkg::PIX_W];
  assign rd_mid = rd_word[mf3_pkg::PIX_W-1:0];

  mf3_ram #(
    .WIDTH(mf3_pkg::LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_v_r && advance),
    .waddr (ADDR_W'(s1_side_r.x)),
    .wdata ({rd_mid, s1_side_r.p}),
    .re    (accept),
    .raddr (ADDR_W'(col_r)),
    .rdata (rd_word)
  );

  always_comb begin
    s1_tag       = s1_side_r;
    s1_tag.mid   = rd_mid;
    win_nxt[0]   = win_r[0];
    win_nxt[1]   = win_r[1];
    win_nxt[2]   = {s1_side_r.p, rd_mid, rd_up};
  end

  mf3_median u_median (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .v_in    (s1_v_r),
    .tag_in  (s1_tag),
    .win_in  (win_nxt),
    .v_out   (med_v),
    .tag_out (med_tag),
    .med_out (med_pix)
  );

  mf3_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (med_v),
    .item_tag   (med_tag),
    .item_med   (med_pix),
    .take       (ser_take),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .pixel_out  (out_ch.pixel_out),
    .out_col    (out_ch.out_col),
    .out_row    (out_ch.out_row),
    .run_last   (out_ch.run_last)
  );

endmodule

// ===== hdl/mf3_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/mf3_median.sv =====
// Three-stage pipelined nine-input median with a carried item tag.
// Depends on mf3_pkg.
`timescale 1ns / 1ps

module mf3_median (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_in,
  input  mf3_pkg::side_t    tag_in,
  input  mf3_pkg::col_t [2:0] win_in,
  output logic              v_out,
  output mf3_pkg::side_t    tag_out,
  output mf3_pkg::pix_t     med_out
);

  logic                a_v_r;
  logic                b_v_r;
  logic                c_v_r;
  mf3_pkg::side_t      a_tag_r;
  mf3_pkg::side_t      b_tag_r;
  mf3_pkg::side_t      c_tag_r;
  mf3_pkg::col_t [2:0] a_sort_r;
  mf3_pkg::col_t       b_trio_r;
  mf3_pkg::pix_t       c_med_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= v_in;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  // sort each column, then max of lows / median of mids / min of highs
  always_ff @(posedge clk) begin
    if (en) begin
      a_tag_r     <= tag_in;
      for (int i = 0; i < 3; i++) begin
        a_sort_r[i] <= mf3_pkg::sort3(win_in[i]);
      end
      b_tag_r     <= a_tag_r;
      b_trio_r[0] <= mf3_pkg::max3(a_sort_r[0][0], a_sort_r[1][0], a_sort_r[2][0]);
      b_trio_r[1] <= mf3_pkg::med3(a_sort_r[0][1], a_sort_r[1][1], a_sort_r[2][1]);
      b_trio_r[2] <= mf3_pkg::min3(a_sort_r[0][2], a_sort_r[1][2], a_sort_r[2][2]);
      c_tag_r     <= b_tag_r;
      c_med_r     <= mf3_pkg::med3(b_trio_r[0], b_trio_r[1], b_trio_r[2]);
    end
  end

  assign v_out   = c_v_r;
  assign tag_out = c_tag_r;
  assign med_out = c_med_r;

endmodule

// ===== hdl/mf3_serial.sv =====
// Output serializer: spreads the zero to three results of one pixel over
// successive result transfers behind a registered output. Depends on mf3_pkg.
`timescale 1ns / 1ps

module mf3_serial (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  mf3_pkg::side_t      item_tag,
  input  mf3_pkg::pix_t       item_med,
  output logic                take,
  input  logic                out_ready,
  output logic                out_valid,
  output mf3_pkg::pix_t       pixel_out,
  output mf3_pkg::pos_t       out_col,
  output mf3_pkg::pos_t       out_row,
  output logic                run_last
);

  // pending results: [2] median, [1] border pixel, [0] echo
  logic [2:0]     pend_r;
  logic [2:0]     rest;
  logic           out_valid_r;
  logic           load_ok;
  logic           emit;
  mf3_pkg::side_t hold_r;
  mf3_pkg::pix_t  hold_med_r;
  mf3_pkg::pix_t  sel_pix;
  mf3_pkg::pos_t  sel_col;
  mf3_pkg::pos_t  sel_row;
  mf3_pkg::pix_t  pixel_out_r;
  mf3_pkg::pos_t  out_col_r;
  mf3_pkg::pos_t  out_row_r;
  logic           run_last_r;

  always_comb begin
    load_ok = !out_valid_r || out_ready;
    emit    = load_ok && (pend_r != 3'b000);
    rest    = pend_r;
    if (pend_r[2]) begin
      sel_pix = hold_med_r;
      sel_col = hold_r.x - mf3_pkg::POS_W'(1);
      sel_row = hold_r.y - mf3_pkg::POS_W'(1);
      rest[2] = 1'b0;
    end else if (pend_r[1]) begin
      sel_pix = hold_r.mid;
      sel_col = hold_r.x;
      sel_row = hold_r.y - mf3_pkg::POS_W'(1);
      rest[1] = 1'b0;
    end else begin
      sel_pix = hold_r.p;
      sel_col = hold_r.x;
      sel_row = hold_r.y;
      rest[0] = 1'b0;
    end
    take = (pend_r == 3'b000) || (emit && (rest == 3'b000));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 3'b000;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        pend_r <= item_valid ? {item_tag.f_med, item_tag.f_bord, item_tag.f_echo} : 3'b000;
      end else if (emit) begin
        pend_r <= rest;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && item_valid) begin
      hold_r     <= item_tag;
      hold_med_r <= item_med;
    end
    if (emit) begin
      pixel_out_r <= sel_pix;
      out_col_r   <= sel_col;
      out_row_r   <= sel_row;
      run_last_r  <= (rest == 3'b000);
    end
  end

  assign out_valid = out_valid_r;
  assign pixel_out = pixel_out_r;
  assign out_col   = out_col_r;
  assign out_row   = out_row_r;
  assign run_last  = run_last_r;

endmodule

// ===== hdl/mf3_checker.sv =====
// Port-level checker for the 3x3 median filter core, bound to the top level.
// Depends on mf3_pkg and median_filter_3x3_stream_core_macros.svh.
`timescale 1ns / 1ps
`include "median_filter_3x3_stream_core_macros.svh"

module mf3_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mf3_pkg::pix_t       pixel_out,
  input mf3_pkg::pos_t       out_col,
  input mf3_pkg::pos_t       out_row,
  input logic                run_last
);

  `MF3_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  `MF3_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(pixel_out) && $stable(out_col) && $stable(out_row) && $stable(run_last), "result changed while stalled")

  // results of one pixel leave back to back
  `MF3_ASSERT(a_run_burst, out_valid && out_ready && !run_last |=> out_valid, "gap inside a result run")

  `MF3_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind median_filter_3x3_stream_core mf3_checker u_mf3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pixel_out (out_ch.pixel_out),
  .out_col   (out_ch.out_col),
  .out_row   (out_ch.out_row),
  .run_last  (out_ch.run_last)
);

// ===== bench/median_filter_3x3_stream_core_tb.sv =====
// Self-checking bench for median_filter_3x3_stream_core: random and directed frames,
// a built-in 3x3 median predictor, per-result comparison in arrival order.
// Depends on mf3_pkg, mf3_ifs and the core RTL.
`timescale 1ns / 1ps

module median_filter_3x3_stream_core_tb;

  localparam int LINE_DEPTH   = 4096;
  localparam int IDLE_MAX     = 19;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 200;
  localparam int WIDE_ITEMS   = 40;
  localparam int SHOW_LIMIT   = 10;
  localparam int WIN_TAPS     = 9;
  localparam int WIN_MID      = 4;
  localparam int PIX_MAX      = (1 << mf3_pkg::PIX_W) - 1;
  localparam logic [mf3_pkg::SIZE_W-1:0] SIZE_ALL_ONES = '1;
  localparam logic [mf3_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST =
    mf3_pkg::REG_IMAGE_HEIGHT + 1'b1;
  localparam logic [mf3_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  typedef struct packed {
    mf3_pkg::pix_t pixel;
    mf3_pkg::pos_t col;
    mf3_pkg::pos_t row;
    logic last;
  } out_pix_t;

  logic clk;
  logic rst_n;

  mf3_pix_if pix_bus ();
  mf3_res_if res_bus ();
  mf3_cfg_if cfg_bus ();

  median_filter_3x3_stream_core #(
    .MAX_WIDTH(LINE_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(pix_bus),
    .out_ch(res_bus),
    .cfg_ch(cfg_bus)
  );

  // predictor state
  logic [mf3_pkg::SIZE_W-1:0] width_reg;
  logic [mf3_pkg::SIZE_W-1:0] height_reg;
  mf3_pkg::pix_t line_upper [LINE_DEPTH];
  mf3_pkg::pix_t line_middle [LINE_DEPTH];
  mf3_pkg::pix_t win [WIN_TAPS];
  int cur_col;
  int cur_row;

  out_pix_t expected_pixels [$];
  mf3_pkg::pix_t pix_pending [$];
  bit pix_xfer;
  bit res_xfer;
  int in_wait;
  int out_wait;
  int out_hold;
  int in_gap_max;
  int out_gap_max;
  int stalls_asked;
  int stalls_done;
  int err_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int held_size(logic [mf3_pkg::SIZE_W-1:0] v, int limit);
    int s;
    s = int'(v);
    if (s < mf3_pkg::MIN_SIZE) s = mf3_pkg::MIN_SIZE;
    if (s > limit) s = limit;
    return s;
  endfunction

  function automatic mf3_pkg::pix_t window_median();
    mf3_pkg::pix_t s [WIN_TAPS];
    mf3_pkg::pix_t k;
    int j;
    for (int i = 0; i < WIN_TAPS; i++) s[i] = win[i];
    for (int i = 1; i < WIN_TAPS; i++) begin
      k = s[i];
      j = i - 1;
      while (j >= 0 && s[j] > k) begin
        s[j + 1] = s[j];
        j--;
      end
      s[j + 1] = k;
    end
    return s[WIN_MID];
  endfunction

  function automatic out_pix_t make_result(mf3_pkg::pix_t p, int col, int row);
    out_pix_t r;
    r.pixel = p;
    r.col = mf3_pkg::pos_t'(col);
    r.row = mf3_pkg::pos_t'(row);
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void apply_reg(logic [mf3_pkg::CFG_IDX_W-1:0] idx,
                                    logic [mf3_pkg::SIZE_W-1:0] val);
    case (idx)
      mf3_pkg::REG_IMAGE_WIDTH: begin
        width_reg = val;
        cur_col = 0;
        cur_row = 0;
      end
      mf3_pkg::REG_IMAGE_HEIGHT: begin
        height_reg = val;
        cur_col = 0;
        cur_row = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic void filter_pixel(mf3_pkg::pix_t p);
    int w;
    int h;
    int x;
    int y;
    mf3_pkg::pix_t up;
    mf3_pkg::pix_t md;
    out_pix_t r;
    out_pix_t burst [$];
    w = held_size(width_reg, LINE_DEPTH);
    h = held_size(height_reg, mf3_pkg::COUNT_LIMIT);
    x = cur_col;
    y = cur_row;
    up = line_upper[x];
    md = line_middle[x];
    line_upper[x] = md;
    line_middle[x] = p;
    for (int i = 0; i < 3; i++) begin
      win[i * 3] = win[i * 3 + 1];
      win[i * 3 + 1] = win[i * 3 + 2];
    end
    win[2] = up;
    win[5] = md;
    win[8] = p;
    if (y == 0) begin
      burst.push_back(make_result(p, x, 0));
    end else if (y >= 2) begin
      if (x == 0) burst.push_back(make_result(md, 0, y - 1));
      if (x >= 2) burst.push_back(make_result(window_median(), x - 1, y - 1));
      if (x == w - 1) burst.push_back(make_result(md, x, y - 1));
      if (y == h - 1) burst.push_back(make_result(p, x, y));
    end
    foreach (burst[i]) begin
      r = burst[i];
      r.last = (i == burst.size() - 1);
      expected_pixels.push_back(r);
    end
    if (x + 1 >= w) begin
      cur_col = 0;
      cur_row = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      cur_col = x + 1;
    end
  endfunction

  function automatic void check_result();
    out_pix_t got;
    out_pix_t want;
    got.pixel = res_bus.pixel_out;
    got.col = res_bus.out_col;
    got.row = res_bus.out_row;
    got.last = res_bus.run_last;
    if (expected_pixels.size() == 0) begin
      err_count++;
      if (err_count <= SHOW_LIMIT)
        $display("unexpected result: pix %0d at (%0d,%0d) last %0d",
                 got.pixel, got.col, got.row, got.last);
    end else begin
      want = expected_pixels.pop_front();
      if (got.pixel !== want.pixel || got.col !== want.col || got.row !== want.row ||
          got.last !== want.last) begin
        err_count++;
        if (err_count <= SHOW_LIMIT)
          $display({"mismatch: expected pix %0d at (%0d,%0d) last %0d, ",
                    "got pix %0d at (%0d,%0d) last %0d"},
                   want.pixel, want.col, want.row, want.last,
                   got.pixel, got.col, got.row, got.last);
      end
    end
  endfunction

  function automatic mf3_pkg::pix_t draw_pixel();
    case ($urandom_range(3, 0))
      0: return mf3_pkg::pix_t'($urandom_range(3, 0));
      1: return mf3_pkg::pix_t'($urandom_range(PIX_MAX, PIX_MAX - 3));
      default: return mf3_pkg::pix_t'($urandom_range(PIX_MAX, 0));
    endcase
  endfunction

  function automatic void queue_pixels(int count);
    repeat (count) pix_pending.push_back(draw_pixel());
  endfunction

  // monitor: config, result check and prediction on each transfer
  always @(posedge clk) begin
    pix_xfer = 1'b0;
    res_xfer = 1'b0;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) apply_reg(cfg_bus.index, cfg_bus.data);
      if (res_bus.valid && res_bus.ready) begin
        res_xfer = 1'b1;
        check_result();
      end
      if (pix_bus.valid && pix_bus.ready) begin
        pix_xfer = 1'b1;
        filter_pixel(pix_bus.pixel_in);
      end
    end
  end

  // pixel driver
  always @(negedge clk) begin
    if (pix_xfer) begin
      void'(pix_pending.pop_front());
      in_wait = $urandom_range(in_gap_max, 0);
    end
    if (pix_pending.size() != 0 && in_wait == 0) begin
      pix_bus.valid <= 1'b1;
      pix_bus.pixel_in <= pix_pending[0];
    end else begin
      if (pix_pending.size() != 0) in_wait--;
      pix_bus.valid <= 1'b0;
    end
  end

  // result receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (stalls_done != stalls_asked) begin
      stalls_done = stalls_asked;
      out_hold = HOLD_CYCLES;
    end
    if (res_xfer) out_wait = $urandom_range(out_gap_max, 0);
    if (out_hold > 0) begin
      out_hold--;
      res_bus.ready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [mf3_pkg::CFG_IDX_W-1:0] idx,
                           logic [mf3_pkg::SIZE_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_size(logic [mf3_pkg::SIZE_W-1:0] wv, logic [mf3_pkg::SIZE_W-1:0] hv);
    write_reg(mf3_pkg::REG_IMAGE_WIDTH, wv);
    write_reg(mf3_pkg::REG_IMAGE_HEIGHT, hv);
  endtask

  task automatic wait_drained();
    while (pix_pending.size() != 0 || expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling();
    in_gap_max = ($urandom_range(2, 0) == 0) ? 0 : IDLE_MAX;
    out_gap_max = ($urandom_range(2, 0) == 0) ? 0 : IDLE_MAX;
  endtask

  initial begin
    mf3_pkg::pix_t frame_a [9];
    mf3_pkg::pix_t frame_b [9];
    int ew;
    int eh;
    int count;
    int random_items;
    logic [mf3_pkg::SIZE_W-1:0] wv;
    logic [mf3_pkg::SIZE_W-1:0] hv;

    rst_n = 1'b0;
    pix_bus.valid = 1'b0;
    pix_bus.pixel_in = '0;
    res_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    width_reg = mf3_pkg::SIZE_W'(mf3_pkg::RST_WIDTH);
    height_reg = mf3_pkg::SIZE_W'(mf3_pkg::RST_HEIGHT);
    foreach (line_upper[i]) line_upper[i] = '0;
    foreach (line_middle[i]) line_middle[i] = '0;
    foreach (win[i]) win[i] = '0;
    cur_col = 0;
    cur_row = 0;
    in_wait = 0;
    out_wait = 0;
    out_hold = 0;
    stalls_asked = 0;
    stalls_done = 0;
    err_count = 0;
    random_items = 0;
    in_gap_max = IDLE_MAX;
    out_gap_max = IDLE_MAX;
    frame_a = '{8'd255, 8'd0, 8'd128, 8'd7, 8'd200, 8'd1, 8'd9, 8'd100, 8'd250};
    frame_b = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset sizes: row 0 pixels only, frame left open
    pix_pending.push_back(8'h00);
    pix_pending.push_back(8'hFF);
    pix_pending.push_back(8'h55);
    pix_pending.push_back(8'hAA);
    wait_drained();

    // smallest frame, restarted by the size write
    set_size(mf3_pkg::SIZE_W'(mf3_pkg::MIN_SIZE), mf3_pkg::SIZE_W'(mf3_pkg::MIN_SIZE));
    foreach (frame_a[i]) pix_pending.push_back(frame_a[i]);
    wait_drained();

    // sizes below range, and a write to an unlisted index mid-frame
    set_size('0, mf3_pkg::SIZE_W'(2));
    for (int i = 0; i < 4; i++) pix_pending.push_back(frame_b[i]);
    wait_drained();
    write_reg(REG_SPARE_LAST, SIZE_ALL_ONES);
    for (int i = 4; i < 9; i++) pix_pending.push_back(frame_b[i]);
    wait_drained();

    while (random_items < RANDOM_ITEMS) begin
      set_idling();
      ew = $urandom_range(12, mf3_pkg::MIN_SIZE);
      eh = $urandom_range(6, mf3_pkg::MIN_SIZE);
      wv = mf3_pkg::SIZE_W'(ew);
      hv = mf3_pkg::SIZE_W'(eh);
      if (ew == mf3_pkg::MIN_SIZE && $urandom_range(1, 0) == 1)
        wv = mf3_pkg::SIZE_W'($urandom_range(2, 0));
      if (eh == mf3_pkg::MIN_SIZE && $urandom_range(1, 0) == 1)
        hv = mf3_pkg::SIZE_W'($urandom_range(2, 0));
      if ($urandom_range(1, 0) == 1) begin
        write_reg(mf3_pkg::REG_IMAGE_HEIGHT, hv);
        write_reg(mf3_pkg::REG_IMAGE_WIDTH, wv);
      end else begin
        set_size(wv, hv);
      end
      if ($urandom_range(3, 0) == 0)
        write_reg(mf3_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                  mf3_pkg::SIZE_W'($urandom_range(SIZE_ALL_ONES, 0)));
      if ($urandom_range(3, 0) == 0)
        count = $urandom_range(ew * eh - 1, 1);
      else
        count = ew * eh * $urandom_range(2, 1);
      queue_pixels(count);
      if (random_items == 0) stalls_asked++;
      random_items += count;
      wait_drained();
    end

    // sizes above range and at the top of range
    set_idling();
    set_size(mf3_pkg::SIZE_W'(mf3_pkg::COUNT_LIMIT + 1), mf3_pkg::SIZE_W'(mf3_pkg::MIN_SIZE));
    queue_pixels(10);
    wait_drained();
    set_size(mf3_pkg::SIZE_W'(mf3_pkg::MIN_SIZE), mf3_pkg::SIZE_W'(mf3_pkg::COUNT_LIMIT + 1));
    queue_pixels(18);
    wait_drained();
    set_size(mf3_pkg::SIZE_W'(mf3_pkg::COUNT_LIMIT), mf3_pkg::SIZE_W'(mf3_pkg::COUNT_LIMIT));
    queue_pixels(20);
    wait_drained();

    // start of a frame at the widest row, behind a long receiver hold-off
    in_gap_max = 3;
    out_gap_max = 3;
    set_size(SIZE_ALL_ONES, mf3_pkg::SIZE_W'(mf3_pkg::MIN_SIZE));
    queue_pixels(WIDE_ITEMS);
    stalls_asked++;
    wait_drained();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
